// ===== sv/lcdws_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdws_pkg
// Shared types, constants and the write table for the character-LCD write
// sequencer.
// ----------------------------------------------------------------------------
package lcdws_pkg;

  // request codes
  localparam logic [1:0] REQ_PRINT = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_INIT  = 2'd2;

  // register map (word index taken from paddr[2])
  localparam logic REG_LINE_LENGTH = 1'b0;
  localparam logic REG_SECOND_LINE = 1'b1;

  localparam logic [5:0] LINE_LENGTH_RESET = 6'd16;
  localparam logic [7:0] SECOND_LINE_RESET = 8'hC0;

  // command bytes
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0E;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;

  // bus timings in microseconds
  localparam logic [5:0]  EN_SHORT   = 6'd10;
  localparam logic [5:0]  EN_LONG    = 6'd40;
  localparam logic [10:0] WAIT_SHORT = 11'd40;
  localparam logic [10:0] WAIT_LONG  = 11'd1640;

  // what a queued request still has to send
  typedef enum logic [1:0] {
    JOB_PRINT,
    JOB_PRINT_WRAP,
    JOB_CLEAR,
    JOB_INIT
  } job_kind_t;

  // request held by the front end, seen by the emitter
  typedef struct packed {
    logic      valid;
    job_kind_t kind;
    logic [7:0] char_code;
    logic [1:0] idx;
  } job_t;

  // one bus write
  typedef struct packed {
    logic        reg_select;
    logic [7:0]  bus_byte;
    logic [5:0]  enable_us;
    logic [10:0] wait_us;
    logic        last;
  } lcd_write_t;

  // index of the final write of a job
  function automatic logic [1:0] last_idx(input job_kind_t kind);
    logic [1:0] n;
    case (kind)
      JOB_PRINT_WRAP: n = 2'd1;
      JOB_INIT:       n = 2'd3;
      default:        n = 2'd0;
    endcase
    return n;
  endfunction

  // write number idx of a job
  function automatic lcd_write_t write_of(input job_kind_t kind, input logic [1:0] idx,
                                          input logic [7:0] ch, input logic [7:0] slc);
    lcd_write_t w;
    w = '{reg_select: 1'b0, bus_byte: CMD_CLEAR, enable_us: EN_LONG,
          wait_us: WAIT_LONG, last: 1'b1};
    case (kind)
      JOB_PRINT: begin
        w = '{reg_select: 1'b1, bus_byte: ch, enable_us: EN_LONG,
              wait_us: WAIT_SHORT, last: 1'b1};
      end
      JOB_PRINT_WRAP: begin
        if (idx == 2'd0) begin
          w = '{reg_select: 1'b1, bus_byte: ch, enable_us: EN_LONG,
                wait_us: WAIT_SHORT, last: 1'b0};
        end else begin
          w = '{reg_select: 1'b0, bus_byte: slc, enable_us: EN_SHORT,
                wait_us: WAIT_SHORT, last: 1'b1};
        end
      end
      JOB_INIT: begin
        case (idx)
          2'd0: w = '{reg_select: 1'b0, bus_byte: CMD_FUNCTION_SET, enable_us: EN_SHORT,
                      wait_us: WAIT_SHORT, last: 1'b0};
          2'd1: w = '{reg_select: 1'b0, bus_byte: CMD_ENTRY_MODE, enable_us: EN_SHORT,
                      wait_us: WAIT_SHORT, last: 1'b0};
          2'd2: w = '{reg_select: 1'b0, bus_byte: CMD_DISPLAY_ON, enable_us: EN_SHORT,
                      wait_us: WAIT_SHORT, last: 1'b0};
          default: w = '{reg_select: 1'b0, bus_byte: CMD_CLEAR, enable_us: EN_LONG,
                         wait_us: WAIT_LONG, last: 1'b1};
        endcase
      end
      default: begin
        // clear display: defaults above
      end
    endcase
    return w;
  endfunction

endpackage

// ===== sv/lcdws_regs.sv =====
// ----------------------------------------------------------------------------
// lcdws_regs
// APB-style configuration registers: line length and second-line command.
// ----------------------------------------------------------------------------
module lcdws_regs
  import lcdws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [5:0]  line_length,
  output logic [7:0]  second_line_command
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length         <= LINE_LENGTH_RESET;
      second_line_command <= SECOND_LINE_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_LINE_LENGTH) begin
        line_length <= pwdata[5:0];
      end else begin
        second_line_command <= pwdata[7:0];
      end
    end
  end

  // read mux
  always_comb begin
    if (paddr[2] == REG_SECOND_LINE) begin
      prdata = {24'd0, second_line_command};
    end else begin
      prdata = {26'd0, line_length};
    end
  end

endmodule

// ===== sv/lcdws_front.sv =====
// ----------------------------------------------------------------------------
// lcdws_front
// Accepts requests, keeps the character count and holds the job being sent.
// ----------------------------------------------------------------------------
module lcdws_front
  import lcdws_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [7:0] char_code,
  input  logic [5:0] line_length,
  input  logic       take,
  output job_t       job
);

  logic       char_count_en;
  logic [5:0] char_count;
  logic [5:0] char_count_next;
  logic [5:0] count_inc;
  logic       accept;
  logic       last_step;
  logic       job_load;
  job_kind_t  kind_next;

  // the job frees up as its final write goes into the output register
  assign last_step = job.idx == last_idx(job.kind);
  assign in_stall  = job.valid && !(take && last_step);
  assign accept    = in_valid && !in_stall;
  assign count_inc = char_count + 6'd1;

  // request decode and count update
  always_comb begin
    kind_next       = JOB_PRINT;
    job_load        = 1'b0;
    char_count_en   = 1'b0;
    char_count_next = char_count;
    case (req_type)
      REQ_PRINT: begin
        job_load      = 1'b1;
        char_count_en = 1'b1;
        if (count_inc == line_length) begin
          kind_next       = JOB_PRINT_WRAP;
          char_count_next = 6'd0;
        end else begin
          char_count_next = count_inc;
        end
      end
      REQ_CLEAR: begin
        kind_next       = JOB_CLEAR;
        job_load        = 1'b1;
        char_count_en   = 1'b1;
        char_count_next = 6'd0;
      end
      REQ_INIT: begin
        kind_next = JOB_INIT;
        job_load  = 1'b1;
      end
      default: begin
        // unused code: dropped without effect
      end
    endcase
  end

  // character count
  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= 6'd0;
    end else if (accept && char_count_en) begin
      char_count <= char_count_next;
    end
  end

  // job register and write index
  always_ff @(posedge clk) begin
    if (rst) begin
      job.valid <= 1'b0;
      job.idx   <= 2'd0;
    end else if (accept) begin
      job.valid     <= job_load;
      job.idx       <= 2'd0;
      job.kind      <= kind_next;
      job.char_code <= char_code;
    end else if (job.valid && take) begin
      if (last_step) begin
        job.valid <= 1'b0;
      end else begin
        job.idx <= job.idx + 2'd1;
      end
    end
  end

  // write index stays within the job
  assert property (@(posedge clk) disable iff (rst)
    job.valid |-> job.idx <= last_idx(job.kind))
    else $error("write index past end of job");

  // no new request while a job has writes left after this cycle
  assert property (@(posedge clk) disable iff (rst)
    (job.valid && !last_step) |-> in_stall)
    else $error("request taken while job unfinished");

  // a clear request zeroes the count
  assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_CLEAR) |=> char_count == 6'd0)
    else $error("count not cleared");

endmodule

// ===== sv/lcdws_emit.sv =====
// ----------------------------------------------------------------------------
// lcdws_emit
// Output register: builds one bus write per cycle from the held job, unless the receiver stalls.
// ----------------------------------------------------------------------------
module lcdws_emit
  import lcdws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  job_t        job,
  input  logic [7:0]  second_line_command,
  output logic        take,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        reg_select,
  output logic [7:0]  bus_byte,
  output logic [5:0]  enable_us,
  output logic [10:0] wait_us,
  output logic        last
);

  lcd_write_t wr;
  lcd_write_t wr_next;

  // output register can load when empty or being drained
  assign take    = !out_valid || !out_stall;
  assign wr_next = write_of(job.kind, job.idx, job.char_code, second_line_command);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= job.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && job.valid) begin
      wr <= wr_next;
    end
  end

  assign reg_select = wr.reg_select;
  assign bus_byte   = wr.bus_byte;
  assign enable_us  = wr.enable_us;
  assign wait_us    = wr.wait_us;
  assign last       = wr.last;

  // a pending write always reaches the output register
  assert property (@(posedge clk) disable iff (rst)
    (take && job.valid) |=> out_valid)
    else $error("write lost at output register");

  // init sequence ends with the long clear timing
  assert property (@(posedge clk) disable iff (rst)
    (take && job.valid && job.kind == JOB_INIT && job.idx == 2'd3)
      |=> (last && wait_us == WAIT_LONG))
    else $error("init sequence tail wrong");

endmodule

// ===== sv/char_lcd_write_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_top
// Turns print, clear and initialise requests into 8-bit character-LCD writes.
// ----------------------------------------------------------------------------
// Each accepted request becomes one to four bus writes, sent one per clock
// when not stalled, through a single output register: a print is one write
// (two when it ends a line and the second-line command follows), a clear one
// write and an initialise four. The next request is taken in the cycle its
// predecessor's final write enters the output register, so requests flow
// back to back; the write emitter is the only rate limit. Unused request
// code 3 is taken and dropped. Configuration is read at address 0 (line
// length) and 4 (second-line command); write it only while idle.
module char_lcd_write_sequencer_top
  import lcdws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        reg_select,
  output logic [7:0]  bus_byte,
  output logic [5:0]  enable_us,
  output logic [10:0] wait_us,
  output logic        last
);

  logic [5:0] line_length;
  logic [7:0] second_line_command;
  logic       take;
  job_t       job;

  // configuration registers
  lcdws_regs u_regs (
    .clk                 (clk),
    .rst                 (rst),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .line_length         (line_length),
    .second_line_command (second_line_command)
  );

  // request intake and character count
  lcdws_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .char_code   (char_code),
    .line_length (line_length),
    .take        (take),
    .job         (job)
  );

  // write emitter
  lcdws_emit u_emit (
    .clk                 (clk),
    .rst                 (rst),
    .job                 (job),
    .second_line_command (second_line_command),
    .take                (take),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .reg_select          (reg_select),
    .bus_byte            (bus_byte),
    .enable_us           (enable_us),
    .wait_us             (wait_us),
    .last                (last)
  );

endmodule

// ===== tb/tb_char_lcd_write_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// tb_char_lcd_write_sequencer_top
// Self-checking bench for the character-LCD write sequencer.
// ----------------------------------------------------------------------------
// Print, clear and initialise requests go in one word at a time. A
// scoreboard works out the bus writes each request must produce, keeping
// its own copy of the line length, the second-line command and the
// character count. Every write that leaves the block is compared with the
// oldest write still owed. The run covers a directed opening, then random
// phases under several register settings. Sender gaps and receiver stalls
// vary from phase to phase, and one long receiver hold-off fills the block.
module tb_char_lcd_write_sequencer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lcdws_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLDOFF_CYCLES = 300;

  // owed bus writes and the sequencer state behind them
  class lcd_write_scoreboard;
    logic [5:0] line_len;
    logic [7:0] line2_cmd;
    logic [5:0] chars_on_line;
    lcd_write_t owed_writes[$];
    int unsigned errors;

    function new();
      line_len = LINE_LENGTH_RESET;
      line2_cmd = SECOND_LINE_RESET;
      chars_on_line = '0;
      errors = 0;
    endfunction

    function void set_register(logic reg_idx, logic [31:0] value);
      if (reg_idx == REG_LINE_LENGTH) begin
        line_len = value[5:0];
      end else begin
        line2_cmd = value[7:0];
      end
    endfunction

    function void owe_write(logic rs, logic [7:0] data, logic [5:0] en_us,
                            logic [10:0] wt_us, logic fin);
      owed_writes.push_back('{reg_select: rs, bus_byte: data, enable_us: en_us,
                              wait_us: wt_us, last: fin});
    endfunction

    // one accepted request word
    function void note_request(logic [1:0] req, logic [7:0] ch);
      case (req)
        REQ_PRINT: begin
          chars_on_line = chars_on_line + 6'd1;
          if (chars_on_line == line_len) begin
            owe_write(1'b1, ch, EN_LONG, WAIT_SHORT, 1'b0);
            owe_write(1'b0, line2_cmd, EN_SHORT, WAIT_SHORT, 1'b1);
            chars_on_line = '0;
          end else begin
            owe_write(1'b1, ch, EN_LONG, WAIT_SHORT, 1'b1);
          end
        end
        REQ_CLEAR: begin
          owe_write(1'b0, CMD_CLEAR, EN_LONG, WAIT_LONG, 1'b1);
          chars_on_line = '0;
        end
        REQ_INIT: begin
          owe_write(1'b0, CMD_FUNCTION_SET, EN_SHORT, WAIT_SHORT, 1'b0);
          owe_write(1'b0, CMD_ENTRY_MODE, EN_SHORT, WAIT_SHORT, 1'b0);
          owe_write(1'b0, CMD_DISPLAY_ON, EN_SHORT, WAIT_SHORT, 1'b0);
          owe_write(1'b0, CMD_CLEAR, EN_LONG, WAIT_LONG, 1'b1);
        end
        default: begin
          // unused code: dropped, no state change
        end
      endcase
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    // one accepted bus write word
    function void check_write(lcd_write_t got);
      lcd_write_t want;
      if (owed_writes.size() == 0) begin
        errors++;
        $display("%0t: unexpected write, expected none, got rs %0d byte 'h%0h en %0d wait %0d last %0d",
                 $time, got.reg_select, got.bus_byte, got.enable_us, got.wait_us, got.last);
      end else begin
        want = owed_writes.pop_front();
        compare_field("reg_select", want.reg_select, got.reg_select);
        compare_field("bus_byte", want.bus_byte, got.bus_byte);
        compare_field("enable_us", want.enable_us, got.enable_us);
        compare_field("wait_us", want.wait_us, got.wait_us);
        compare_field("last", want.last, got.last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = '0;
  logic [7:0]  char_code = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        reg_select;
  logic [7:0]  bus_byte;
  logic [5:0]  enable_us;
  logic [10:0] wait_us;
  logic        last;

  lcd_write_scoreboard board;
  int unsigned send_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned holdoff_requested = 0;
  int unsigned cycle_count = 0;

  char_lcd_write_sequencer_top uut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .char_code  (char_code),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .reg_select (reg_select),
    .bus_byte   (bus_byte),
    .enable_us  (enable_us),
    .wait_us    (wait_us),
    .last       (last)
  );

  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiving side: check each write word, stall at random or hold off
  initial begin
    int unsigned holdoff_served;
    int unsigned holdoff_left;
    holdoff_served = 0;
    holdoff_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        board.check_write('{reg_select: reg_select, bus_byte: bus_byte,
                            enable_us: enable_us, wait_us: wait_us, last: last});
      end
      @(negedge clk);
      if (holdoff_requested != holdoff_served) begin
        holdoff_served = holdoff_requested;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
      end
    end
  end

  // offer one request word, with random gaps ahead of it
  task automatic offer_request(input logic [1:0] req, input logic [7:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    char_code <= ch;
    do @(posedge clk); while (in_stall);
    board.note_request(req, ch);
    @(negedge clk);
  endtask

  // stop offering and let every owed write come out
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (board.owed_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // register write, then read back
  task automatic write_register(input logic reg_idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_register(reg_idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    psel <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == REG_LINE_LENGTH) begin
      board.compare_field("line_length readback", board.line_len, prdata[5:0]);
    end else begin
      board.compare_field("second_line readback", board.line2_cmd, prdata[7:0]);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // random mix of requests, mostly prints
  task automatic run_phase(input int n_items, input int unsigned send_pct,
                           input int unsigned stall_pct, input int unsigned clear_pct,
                           input int unsigned init_pct, input bit with_holdoff);
    int i;
    int unsigned pick;
    logic [1:0] req;
    send_idle_pct = send_pct;
    out_stall_pct <= stall_pct;
    for (i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < clear_pct) begin
        req = REQ_CLEAR;
      end else if (pick < clear_pct + init_pct) begin
        req = REQ_INIT;
      end else if (pick < clear_pct + init_pct + 4) begin
        req = REQ_UNUSED;
      end else begin
        req = REQ_PRINT;
      end
      if (with_holdoff && i == n_items / 3) begin
        holdoff_requested <= holdoff_requested + 1;
      end
      offer_request(req, 8'($urandom_range(255)));
    end
    settle_idle();
  endtask

  // main sequence
  initial begin
    int i;
    board = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: every request, byte extremes, ignored code, mid-line init,
    // and a full line at the reset length
    offer_request(REQ_INIT, 8'h00);
    offer_request(REQ_CLEAR, 8'hFF);
    offer_request(REQ_PRINT, 8'h00);
    offer_request(REQ_PRINT, 8'hFF);
    offer_request(REQ_PRINT, 8'hAA);
    offer_request(REQ_PRINT, 8'h55);
    offer_request(REQ_UNUSED, 8'hFF);
    offer_request(REQ_INIT, 8'h41);
    for (i = 0; i < 12; i++) begin
      offer_request(REQ_PRINT, 8'(8'h30 + i));
    end
    offer_request(REQ_PRINT, 8'h7E);
    offer_request(REQ_CLEAR, 8'h00);
    settle_idle();

    // shortest line, zero second-line command
    write_register(REG_LINE_LENGTH, 32'd1);
    write_register(REG_SECOND_LINE, 32'h00);
    run_phase(70, 0, 0, 8, 8, 1'b0);

    // longest line, all-ones command
    write_register(REG_LINE_LENGTH, 32'd40);
    write_register(REG_SECOND_LINE, 32'hFF);
    run_phase(80, 53, 0, 3, 5, 1'b0);

    // length lowered below the count left over, long receiver hold-off
    write_register(REG_LINE_LENGTH, 32'd5);
    write_register(REG_SECOND_LINE, 32'h3C);
    run_phase(70, 0, 53, 6, 8, 1'b1);

    // zero length: new line only when the count wraps
    write_register(REG_LINE_LENGTH, 32'd0);
    write_register(REG_SECOND_LINE, 32'h80);
    run_phase(90, 15, 15, 0, 3, 1'b0);

    // top of the counter range
    write_register(REG_LINE_LENGTH, 32'd63);
    write_register(REG_SECOND_LINE, 32'($urandom_range(255)));
    run_phase(50, 0, 0, 1, 3, 1'b0);

    // random setting within the usual range
    write_register(REG_LINE_LENGTH, 32'($urandom_range(40, 2)));
    write_register(REG_SECOND_LINE, 32'($urandom_range(255)));
    run_phase(50, 15, 15, 8, 8, 1'b0);

    if (board.errors == 0 && board.owed_writes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
